/* design/point_light_pixel_shader_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the point light pixel shader
// Each macro expands to a clocked concurrent assertion, or to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef POINT_LIGHT_PIXEL_SHADER_TOP_MACROS_SVH
`define POINT_LIGHT_PIXEL_SHADER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* design/pls_pkg.sv */
// ----------------------------------------------------------------------------
// pls_pkg
// Types, codes and constants shared by the point light pixel shader.
// ----------------------------------------------------------------------------
package pls_pkg;

  localparam int LIGHT_SLOTS_DEFAULT = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] MODE_SHADE  = 2'd0;
  localparam logic [1:0] MODE_ADD    = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] CFG_AMBIENT_RED   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_AMBIENT_GREEN = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_AMBIENT_BLUE  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_AMBIENT_GAIN  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_CONTRIB   = 3'd4;

  localparam logic [15:0] AMBIENT_COLOR_RESET = 16'd1229;
  localparam logic [15:0] AMBIENT_GAIN_RESET  = 16'd819;
  localparam logic [15:0] MIN_CONTRIB_RESET   = 16'd655;

  typedef enum logic [1:0] {
    OP_SHADE,
    OP_ADD,
    OP_REMOVE,
    OP_CLEAR
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_INIT,
    ST_READ,
    ST_DATA,
    ST_MUL,
    ST_CHK,
    ST_SQRT,
    ST_DIV,
    ST_ATT,
    ST_GAIN,
    ST_ACC,
    ST_NEXT,
    ST_SCALE,
    ST_ROUND,
    ST_RM_STEP,
    ST_RM_READ,
    ST_RM_WRITE,
    ST_RESP
  } back_state_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [31:0]        pixel_rgba;
    logic [15:0]        light_red;
    logic [15:0]        light_green;
    logic [15:0]        light_blue;
    logic [15:0]        light_intensity;
    logic [23:0]        light_radius;
    logic [4:0]         light_index;
  } pixel_in_t;

  typedef struct packed {
    logic [31:0] color;
    logic [4:0]  slot;
    logic [1:0]  status;
    logic [5:0]  light_count;
  } pixel_out_t;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic [15:0]        red;
    logic [15:0]        green;
    logic [15:0]        blue;
    logic [15:0]        gain;
    logic [23:0]        radius;
  } light_t;

  typedef struct packed {
    op_t         op;
    light_t      light;
    logic [31:0] pixel_rgba;
    logic [4:0]  index;
  } cmd_t;

  typedef struct packed {
    logic [15:0] amb_red;
    logic [15:0] amb_green;
    logic [15:0] amb_blue;
    logic [15:0] amb_gain;
    logic [15:0] min_contrib;
  } cfg_t;

endpackage

/* design/point_light_pixel_shader_top.sv */
// Shade reads each light in the table in turn. A light in reach goes through a 24-step
// root and a 17-step divide, and a faint one is not added in; a light out of reach skips
// both. Remove moves each later light down by one slot to compact the table. Add and
// clear need no table walk. One item is worked on at a time.
// A 2-entry command queue keeps accepting while the back end works.
// Reset (rst, synchronous) empties the table and loads the register defaults.
// ----------------------------------------------------------------------------
// point_light_pixel_shader_top
// 2D point light shader with a compacting light table and config registers.
// ----------------------------------------------------------------------------
module point_light_pixel_shader_top #(
  parameter int LIGHT_SLOTS = pls_pkg::LIGHT_SLOTS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  pls_pkg::pixel_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output pls_pkg::pixel_out_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pls_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]                     cfg_data
);

  pls_pkg::cfg_t cfg;
  pls_pkg::cmd_t cmd;
  logic          cmd_valid;
  logic          cmd_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.amb_red     <= pls_pkg::AMBIENT_COLOR_RESET;
      cfg.amb_green   <= pls_pkg::AMBIENT_COLOR_RESET;
      cfg.amb_blue    <= pls_pkg::AMBIENT_COLOR_RESET;
      cfg.amb_gain    <= pls_pkg::AMBIENT_GAIN_RESET;
      cfg.min_contrib <= pls_pkg::MIN_CONTRIB_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        pls_pkg::CFG_AMBIENT_RED:   cfg.amb_red     <= cfg_data;
        pls_pkg::CFG_AMBIENT_GREEN: cfg.amb_green   <= cfg_data;
        pls_pkg::CFG_AMBIENT_BLUE:  cfg.amb_blue    <= cfg_data;
        pls_pkg::CFG_AMBIENT_GAIN:  cfg.amb_gain    <= cfg_data;
        pls_pkg::CFG_MIN_CONTRIB:   cfg.min_contrib <= cfg_data;
        default:                    cfg.amb_red     <= cfg.amb_red;
      endcase
    end
  end

  pls_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd)
  );

  pls_back #(
    .LIGHT_SLOTS(LIGHT_SLOTS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

/* design/pls_ram.sv */
// ----------------------------------------------------------------------------
// pls_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/pls_front.sv */
// ----------------------------------------------------------------------------
// pls_front
// Accepts input beats, decodes the mode and queues commands for the back end.
// ----------------------------------------------------------------------------
module pls_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  pls_pkg::pixel_in_t in_data,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output pls_pkg::cmd_t     cmd
);

  pls_pkg::cmd_t queue [pls_pkg::QUEUE_DEPTH];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  pls_pkg::cmd_t decoded;
  logic          push;
  logic          pop;

  always_comb begin
    decoded.light.x      = in_data.pos_x;
    decoded.light.y      = in_data.pos_y;
    decoded.light.red    = in_data.light_red;
    decoded.light.green  = in_data.light_green;
    decoded.light.blue   = in_data.light_blue;
    decoded.light.gain   = in_data.light_intensity;
    decoded.light.radius = in_data.light_radius;
    decoded.pixel_rgba   = in_data.pixel_rgba;
    decoded.index        = in_data.light_index;
    case (in_data.mode)
      pls_pkg::MODE_SHADE:  decoded.op = pls_pkg::OP_SHADE;
      pls_pkg::MODE_ADD:    decoded.op = pls_pkg::OP_ADD;
      pls_pkg::MODE_REMOVE: decoded.op = pls_pkg::OP_REMOVE;
      default:              decoded.op = pls_pkg::OP_CLEAR;
    endcase
  end

  assign in_ready  = (count != 2'(pls_pkg::QUEUE_DEPTH));
  assign cmd_valid = (count != 2'd0);
  assign cmd       = queue[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* design/pls_back.sv */
// ----------------------------------------------------------------------------
// pls_back
// Executes commands: table updates, compaction and per-light shading.
// ----------------------------------------------------------------------------
`include "point_light_pixel_shader_top_macros.svh"

module pls_back #(
  parameter int LIGHT_SLOTS = pls_pkg::LIGHT_SLOTS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  pls_pkg::cfg_t      cfg,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  pls_pkg::cmd_t      cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output pls_pkg::pixel_out_t out_data
);

  localparam int AW = (LIGHT_SLOTS > 1) ? $clog2(LIGHT_SLOTS) : 1;
  localparam int CW = $clog2(LIGHT_SLOTS + 1);
  localparam int LW = $bits(pls_pkg::light_t);

  pls_pkg::back_state_t state;
  pls_pkg::back_state_t state_next;

  logic [CW-1:0]      held;
  logic [CW-1:0]      idx;
  pls_pkg::cmd_t      job;
  pls_pkg::light_t    lt;
  pls_pkg::light_t    rdata;
  logic [LW-1:0]      rdata_raw;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [LW-1:0]      ram_wdata;
  logic [AW-1:0]      ram_raddr;

  logic signed [24:0] dx;
  logic signed [24:0] dy;
  logic signed [49:0] dx_sq;
  logic signed [49:0] dy_sq;
  logic [48:0]        dx2;
  logic [48:0]        dy2;
  logic [47:0]        r2;
  logic [49:0]        d2;
  logic               reach;

  logic [47:0]        sq;
  logic [25:0]        sq_rem;
  logic [23:0]        root;
  logic [27:0]        rem_sh;
  logic [27:0]        trial;
  logic               sq_ge;
  logic [23:0]        root_next;
  logic [4:0]         step;

  logic [24:0]        div_rem;
  logic [16:0]        quo;
  logic [24:0]        div_cand;
  logic               div_ge;
  logic [16:0]        lin;
  logic [16:0]        att;
  logic [16:0]        contrib;
  logic               faint;

  logic [39:0]        sum_r;
  logic [39:0]        sum_g;
  logic [39:0]        sum_b;
  logic [47:0]        prod_r;
  logic [47:0]        prod_g;
  logic [47:0]        prod_b;
  logic [7:0]         ch_r;
  logic [7:0]         ch_g;
  logic [7:0]         ch_b;

  logic [31:0]        res_color;
  logic [4:0]         res_slot;
  logic [1:0]         res_status;

  logic               take;
  logic               full;
  logic               bad_index;
  logic               more_lights;
  logic               more_moves;
  logic               load_out;

  pls_ram #(
    .WIDTH(LW),
    .DEPTH(LIGHT_SLOTS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rdata_raw)
  );

  assign rdata       = pls_pkg::light_t'(rdata_raw);
  assign take        = cmd_valid && cmd_ready;
  assign full        = (32'(held) >= 32'(LIGHT_SLOTS));
  assign bad_index   = (32'(cmd.index) >= 32'(held));
  assign more_lights = (32'(idx) + 32'd1 < 32'(held));
  assign more_moves  = more_lights;
  assign load_out    = (state == pls_pkg::ST_RESP) && (!out_valid || out_ready);

  // Distance terms.
  assign dx_sq = dx * dx;
  assign dy_sq = dy * dy;
  assign d2    = 50'(dx2) + 50'(dy2);
  assign reach = (lt.radius != 24'd0) && (d2 <= 50'(r2));

  // One root bit per cycle: two radicand bits shift into the remainder.
  assign rem_sh    = {sq_rem, sq[47:46]};
  assign trial     = {2'b00, root, 2'b01};
  assign sq_ge     = (rem_sh >= trial);
  assign root_next = {root[22:0], sq_ge};

  // Restoring division for the distance ratio; the first step does not shift.
  assign div_cand = (step == 5'd0) ? div_rem : {div_rem[23:0], 1'b0};
  assign div_ge   = (div_cand >= {1'b0, lt.radius});
  assign lin      = 17'h10000 - quo;
  assign faint    = (att < {1'b0, cfg.min_contrib});

  always_comb begin
    state_next = state;
    case (state)
      pls_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            pls_pkg::OP_SHADE:  state_next = pls_pkg::ST_INIT;
            pls_pkg::OP_REMOVE: state_next = bad_index ? pls_pkg::ST_RESP
                                                       : pls_pkg::ST_RM_STEP;
            default:            state_next = pls_pkg::ST_RESP;
          endcase
        end
      end
      pls_pkg::ST_INIT:    state_next = (held == '0) ? pls_pkg::ST_SCALE : pls_pkg::ST_READ;
      pls_pkg::ST_READ:    state_next = pls_pkg::ST_DATA;
      pls_pkg::ST_DATA:    state_next = pls_pkg::ST_MUL;
      pls_pkg::ST_MUL:     state_next = pls_pkg::ST_CHK;
      pls_pkg::ST_CHK:     state_next = reach ? pls_pkg::ST_SQRT : pls_pkg::ST_NEXT;
      pls_pkg::ST_SQRT:    state_next = (step == 5'd23) ? pls_pkg::ST_DIV : pls_pkg::ST_SQRT;
      pls_pkg::ST_DIV:     state_next = (step == 5'd16) ? pls_pkg::ST_ATT : pls_pkg::ST_DIV;
      pls_pkg::ST_ATT:     state_next = pls_pkg::ST_GAIN;
      pls_pkg::ST_GAIN:    state_next = faint ? pls_pkg::ST_NEXT : pls_pkg::ST_ACC;
      pls_pkg::ST_ACC:     state_next = pls_pkg::ST_NEXT;
      pls_pkg::ST_NEXT:    state_next = more_lights ? pls_pkg::ST_READ : pls_pkg::ST_SCALE;
      pls_pkg::ST_SCALE:   state_next = pls_pkg::ST_ROUND;
      pls_pkg::ST_ROUND:   state_next = pls_pkg::ST_RESP;
      pls_pkg::ST_RM_STEP: state_next = more_moves ? pls_pkg::ST_RM_READ : pls_pkg::ST_RESP;
      pls_pkg::ST_RM_READ: state_next = pls_pkg::ST_RM_WRITE;
      pls_pkg::ST_RM_WRITE: state_next = pls_pkg::ST_RM_STEP;
      pls_pkg::ST_RESP:    state_next = load_out ? pls_pkg::ST_IDLE : pls_pkg::ST_RESP;
      default:             state_next = pls_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready = (state == pls_pkg::ST_IDLE);
    ram_we    = 1'b0;
    ram_waddr = held[AW-1:0];
    ram_wdata = cmd.light;
    ram_raddr = idx[AW-1:0];
    case (state)
      pls_pkg::ST_IDLE: begin
        ram_we = cmd_valid && (cmd.op == pls_pkg::OP_ADD) && !full;
      end
      pls_pkg::ST_RM_READ: begin
        ram_raddr = AW'(idx + CW'(1));
      end
      pls_pkg::ST_RM_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = idx[AW-1:0];
        ram_wdata = rdata_raw;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pls_pkg::ST_IDLE;
      held      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (take) begin
        case (cmd.op)
          pls_pkg::OP_ADD:   held <= full ? held : held + CW'(1);
          pls_pkg::OP_CLEAR: held <= '0;
          default:           held <= held;
        endcase
      end else if (state == pls_pkg::ST_RM_STEP && !more_moves) begin
        held <= held - CW'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      job        <= cmd;
      idx        <= '0;
      res_color  <= 32'd0;
      res_slot   <= 5'd0;
      res_status <= pls_pkg::STATUS_OK;
      case (cmd.op)
        pls_pkg::OP_ADD: begin
          if (full) begin
            res_status <= pls_pkg::STATUS_FULL;
          end else begin
            res_slot <= 5'(32'(held));
          end
        end
        pls_pkg::OP_REMOVE: begin
          if (bad_index) begin
            res_status <= pls_pkg::STATUS_RANGE;
          end else begin
            idx <= CW'(cmd.index);
          end
        end
        default: begin
          res_slot <= 5'd0;
        end
      endcase
    end
    case (state)
      pls_pkg::ST_INIT: begin
        sum_r <= 40'(32'(cfg.amb_red) * 32'(cfg.amb_gain));
        sum_g <= 40'(32'(cfg.amb_green) * 32'(cfg.amb_gain));
        sum_b <= 40'(32'(cfg.amb_blue) * 32'(cfg.amb_gain));
      end
      pls_pkg::ST_DATA: begin
        lt <= rdata;
        dx <= 25'(job.light.x) - 25'(rdata.x);
        dy <= 25'(job.light.y) - 25'(rdata.y);
      end
      pls_pkg::ST_MUL: begin
        dx2 <= dx_sq[48:0];
        dy2 <= dy_sq[48:0];
        r2  <= 48'(lt.radius) * 48'(lt.radius);
      end
      pls_pkg::ST_CHK: begin
        sq     <= d2[47:0];
        sq_rem <= 26'd0;
        root   <= 24'd0;
        step   <= 5'd0;
      end
      pls_pkg::ST_SQRT: begin
        sq     <= {sq[45:0], 2'b00};
        sq_rem <= sq_ge ? 26'(rem_sh - trial) : rem_sh[25:0];
        root   <= root_next;
        if (step == 5'd23) begin
          div_rem <= 25'(root_next);
          quo     <= 17'd0;
          step    <= 5'd0;
        end else begin
          step <= step + 5'd1;
        end
      end
      pls_pkg::ST_DIV: begin
        div_rem <= div_ge ? div_cand - {1'b0, lt.radius} : div_cand;
        quo     <= {quo[15:0], div_ge};
        step    <= step + 5'd1;
      end
      pls_pkg::ST_ATT: begin
        att <= 17'((34'(lin) * 34'(lin) + 34'd32768) >> 16);
      end
      pls_pkg::ST_GAIN: begin
        contrib <= 17'((33'(lt.gain) * 33'(att) + 33'd32768) >> 16);
      end
      pls_pkg::ST_ACC: begin
        sum_r <= sum_r + 40'(33'(lt.red) * 33'(contrib));
        sum_g <= sum_g + 40'(33'(lt.green) * 33'(contrib));
        sum_b <= sum_b + 40'(33'(lt.blue) * 33'(contrib));
      end
      pls_pkg::ST_NEXT: begin
        idx <= idx + CW'(1);
      end
      pls_pkg::ST_SCALE: begin
        prod_r <= 48'(job.pixel_rgba[31:24]) * 48'(sum_r);
        prod_g <= 48'(job.pixel_rgba[23:16]) * 48'(sum_g);
        prod_b <= 48'(job.pixel_rgba[15:8]) * 48'(sum_b);
      end
      pls_pkg::ST_ROUND: begin
        res_color <= {ch_r, ch_g, ch_b, job.pixel_rgba[7:0]};
      end
      pls_pkg::ST_RM_WRITE: begin
        idx <= idx + CW'(1);
      end
      default: begin
        step <= step;
      end
    endcase
    if (load_out) begin
      out_data.color       <= res_color;
      out_data.slot        <= res_slot;
      out_data.status      <= res_status;
      out_data.light_count <= 6'(32'(held));
    end
  end

  always_comb begin
    logic [24:0] rr;
    logic [24:0] rg;
    logic [24:0] rb;
    rr   = 25'((49'(prod_r) + 49'h800000) >> 24);
    rg   = 25'((49'(prod_g) + 49'h800000) >> 24);
    rb   = 25'((49'(prod_b) + 49'h800000) >> 24);
    ch_r = (rr > 25'd255) ? 8'hFF : rr[7:0];
    ch_g = (rg > 25'd255) ? 8'hFF : rg[7:0];
    ch_b = (rb > 25'd255) ? 8'hFF : rb[7:0];
  end

  `ASSERT_IMPLIES(a_held_in_range, 1'b1, 32'(held) <= 32'(LIGHT_SLOTS))
  `ASSERT_IMPLIES(a_result_from_resp, $rose(out_valid), $past(state == pls_pkg::ST_RESP))
  `ASSERT_NEXT(a_add_grows, take && cmd.op == pls_pkg::OP_ADD && !full, held == $past(held) + CW'(1))

endmodule
